/* hw/rtl/pafc_pkg.sv */
// Shared types and constants for the pixel alpha format converter.
`default_nettype none

package pafc_pkg;

    // Full-scale channel value
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Reciprocal table: ceil(2^RECIP_SHIFT / a); 24 bits gives exact
    // quotients for all 16-bit numerators and 8-bit divisors
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int NUM_W       = 16;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // Configuration register indexes (paddr[2])
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_PIX_BYTES = 1'b1;

    // Mode register codes
    localparam logic MODE_STORE   = 1'b0;
    localparam logic MODE_TEXTURE = 1'b1;

    // Output byte counts
    localparam logic [2:0] BYTES_THREE = 3'd3;
    localparam logic [2:0] BYTES_FOUR  = 3'd4;

    // Per-lane operation
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_ld;

endpackage

`default_nettype wire

/* hw/rtl/pixel_alpha_format_converter.sv */
// Top level: config registers, pipeline control, three color lanes, merge.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  pixel in | input     | i_valid / o_stall  | i_in_byte0..3
//  pixel out| output    | o_valid / i_stall  | o_out_byte0..3, o_out_bytes_valid
//  config   | APB-style | psel/penable/pready| paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled. The lane
// pipeline stages are lookup, multiply, and scale and saturate.
// Reset clears the stage valid bits and loads mode 1, pixel size 3.
// Stages advance independently: an empty stage fills even while the output
// is stalled, so input is taken until all three stages hold items.
`default_nettype none

module pixel_alpha_format_converter
    import pafc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte0,
    input  wire logic [7:0]  i_in_byte1,
    input  wire logic [7:0]  i_in_byte2,
    input  wire logic [7:0]  i_in_byte3,
    // pixel output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte0,
    output logic [7:0]       o_out_byte1,
    output logic [7:0]       o_out_byte2,
    output logic [7:0]       o_out_byte3,
    output logic [2:0]       o_out_bytes_valid,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic       r_mode;
    logic [2:0] r_pix_bytes;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TEXTURE;
            r_pix_bytes <= BYTES_THREE;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_MODE:      r_mode      <= pwdata[0];
                REG_PIX_BYTES: r_pix_bytes <= pwdata[2:0];
                default:       r_mode      <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE:      prdata = {31'd0, r_mode};
            REG_PIX_BYTES: prdata = {29'd0, r_pix_bytes};
            default:       prdata = '0;
        endcase
    end

    // Pipeline control: each stage loads when its predecessor holds an item and it has room
    logic      r_v1, r_v2, r_v3;
    logic      w_free1, w_free2;
    t_stage_ld w_ld;

    assign w_ld.ld3 = r_v2 && (!r_v3 || !i_stall);
    assign w_free2  = !r_v2 || w_ld.ld3;
    assign w_ld.ld2 = r_v1 && w_free2;
    assign w_free1  = !r_v1 || w_ld.ld2;
    assign w_ld.ld1 = i_valid && w_free1;
    assign o_stall  = !w_free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld.ld1)      r_v1 <= 1'b1;
            else if (w_ld.ld2) r_v1 <= 1'b0;
            if (w_ld.ld2)      r_v2 <= 1'b1;
            else if (w_ld.ld3) r_v2 <= 1'b0;
            if (w_ld.ld3)      r_v3 <= 1'b1;
            else if (!i_stall) r_v3 <= 1'b0;
        end
    end

    assign o_valid = r_v3;

    // Item decode: operation, channel order, alpha and byte count
    logic       w_four;
    logic       w_opaque_or_clear;
    t_op        w_op;
    logic [7:0] w_alpha_out;
    logic [2:0] w_bv;
    logic [7:0] w_lane_in [3];

    assign w_four            = r_pix_bytes[2];
    assign w_opaque_or_clear = (i_in_byte3 == 8'd0) || (i_in_byte3 == FULL_SCALE);

    always_comb begin
        if (r_mode == MODE_STORE) begin
            w_op         = w_four ? OP_MUL : OP_PASS;
            w_alpha_out  = w_four ? i_in_byte3 : 8'd0;
            w_bv         = w_four ? BYTES_FOUR : BYTES_THREE;
            w_lane_in[0] = i_in_byte0;
            w_lane_in[1] = i_in_byte1;
            w_lane_in[2] = i_in_byte2;
        end else begin
            w_op         = (w_four && !w_opaque_or_clear) ? OP_DIV : OP_PASS;
            w_alpha_out  = w_four ? i_in_byte3 : FULL_SCALE;
            w_bv         = BYTES_FOUR;
            w_lane_in[0] = i_in_byte2;
            w_lane_in[1] = i_in_byte1;
            w_lane_in[2] = i_in_byte0;
        end
    end

    // Color lanes
    logic [7:0] w_lane_out [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        pafc_lane u_lane (
            .i_clk   (i_clk),
            .i_ld    (w_ld),
            .i_op    (w_op),
            .i_color (w_lane_in[k]),
            .i_alpha (i_in_byte3),
            .o_color (w_lane_out[k])
        );
    end

    // Alpha and byte count ride alongside the lanes
    logic [7:0] r_a1, r_a2, r_a3;
    logic [2:0] r_bv1, r_bv2, r_bv3;

    always_ff @(posedge i_clk) begin
        if (w_ld.ld1) begin
            r_a1  <= w_alpha_out;
            r_bv1 <= w_bv;
        end
        if (w_ld.ld2) begin
            r_a2  <= r_a1;
            r_bv2 <= r_bv1;
        end
        if (w_ld.ld3) begin
            r_a3  <= r_a2;
            r_bv3 <= r_bv2;
        end
    end

    // Merge lanes into the result item
    assign o_out_byte0       = w_lane_out[0];
    assign o_out_byte1       = w_lane_out[1];
    assign o_out_byte2       = w_lane_out[2];
    assign o_out_byte3       = r_a3;
    assign o_out_bytes_valid = r_bv3;

    // Checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled with a free stage");

    a_three_no_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_bytes_valid == BYTES_THREE) |-> (o_out_byte3 == 8'd0))
        else $error("three-byte result with nonzero alpha");

    a_texture_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == MODE_TEXTURE) |-> (o_out_bytes_valid == BYTES_FOUR))
        else $error("texture result not four bytes");

endmodule

`default_nettype wire

/* hw/rtl/pafc_lane.sv */
// One color channel lane: premultiply, unpremultiply or pass, three stages.
`default_nettype none

module pafc_lane
    import pafc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_stage_ld  i_ld,
    input  wire t_op        i_op,
    input  wire logic [7:0] i_color,
    input  wire logic [7:0] i_alpha,
    output logic [7:0]      o_color
);

    // Reciprocal table, built at elaboration
    logic [RECIP_W-1:0] w_recip [256];

    for (genvar g = 0; g < 256; g++) begin : g_recip
        localparam longint unsigned Den = (g == 0) ? 1 : g;
        localparam longint unsigned RecipVal =
            ((longint'(1) << RECIP_SHIFT) + Den - 1) / Den;
        assign w_recip[g] = RECIP_W'(RecipVal);
    end

    // Stage 1: numerator c*255 and reciprocal lookup
    t_op                r_op1;
    logic [7:0]         r_c1;
    logic [7:0]         r_a1;
    logic [NUM_W-1:0]   r_n1;
    logic [RECIP_W-1:0] r_m1;
    logic [NUM_W-1:0]   n_n1;

    assign n_n1 = {i_color, 8'd0} - NUM_W'(i_color);

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_op1 <= i_op;
            r_c1  <= i_color;
            r_a1  <= i_alpha;
            r_n1  <= n_n1;
            r_m1  <= w_recip[i_alpha];
        end
    end

    // Stage 2: one product per item
    t_op               r_op2;
    logic [7:0]        r_c2;
    logic [PROD_W-1:0] r_p2;
    logic [PROD_W-1:0] n_p2;
    logic [PROD_W-1:0] w_div_prod;
    logic [NUM_W-1:0]  w_mul_prod;

    assign w_div_prod = PROD_W'(r_n1) * PROD_W'(r_m1);
    assign w_mul_prod = NUM_W'(r_c1) * NUM_W'(r_a1);

    always_comb begin
        case (r_op1)
            OP_DIV:  n_p2 = w_div_prod;
            OP_MUL:  n_p2 = PROD_W'(w_mul_prod);
            default: n_p2 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld2) begin
            r_op2 <= r_op1;
            r_c2  <= r_c1;
            r_p2  <= n_p2;
        end
    end

    // Stage 3: scale back, saturate, select
    logic [7:0]                   r_q3;
    logic [7:0]                   n_q3;
    logic [PROD_W-RECIP_SHIFT-1:0] w_quot;
    logic [NUM_W:0]               w_d255;

    assign w_quot = r_p2[PROD_W-1:RECIP_SHIFT];
    // x/255 for x below 2^16: (x + (x >> 8) + 1) >> 8
    assign w_d255 = (NUM_W+1)'(r_p2[NUM_W-1:0])
                  + (NUM_W+1)'(r_p2[NUM_W-1:8]) + (NUM_W+1)'(1);

    always_comb begin
        case (r_op2)
            OP_DIV:  n_q3 = (w_quot > (PROD_W-RECIP_SHIFT)'(FULL_SCALE)) ?
                            FULL_SCALE : w_quot[7:0];
            OP_MUL:  n_q3 = w_d255[15:8];
            default: n_q3 = r_c2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld3) begin
            r_q3 <= n_q3;
        end
    end

    assign o_color = r_q3;

endmodule

`default_nettype wire
